@@ src/hmi_pkg.sv @@
// Shared types, codes and helpers for the indexed min-heap core.
// Used by hmi_front, hmi_back and the top level; depends on nothing else.
package hmi_pkg;

    localparam int ID_W         = 7;
    localparam int SCORE_W      = 32;
    localparam int NUM_IDS      = 64;
    localparam int IDX_W        = 6;
    localparam int DEF_CAPACITY = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [2:0] CMD_FIND   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_ADD    = 3'd3;
    localparam logic [2:0] CMD_SUB    = 3'd4;
    localparam logic [2:0] CMD_CROWN  = 3'd5;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_NOTP  = 3'd1;
    localparam logic [2:0] STAT_DUP   = 3'd2;
    localparam logic [2:0] STAT_FULL  = 3'd3;
    localparam logic [2:0] STAT_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        OP_FIND,
        OP_INSERT,
        OP_REMOVE,
        OP_ADD,
        OP_SUB,
        OP_CROWN,
        OP_NOP
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_RDSLOT,
        S_UP,
        S_UPCMP,
        S_DOWN,
        S_DL,
        S_DR,
        S_DCMP,
        S_PLACE,
        S_CROWNNX,
        S_RDROOT,
        S_RDLAST,
        S_CROWNRD,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op                        op;
        logic [ID_W-1:0]            id;
        logic                       id_ok;
        logic [IDX_W-1:0]           idx;
        logic signed [SCORE_W-1:0]  points;
    } t_req;

    typedef struct packed {
        logic [2:0]                 status;
        logic [ID_W-1:0]            id;
        logic signed [SCORE_W-1:0]  score;
        logic [ID_W-1:0]            loc;
        logic [ID_W-1:0]            count;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic signed [SCORE_W-1:0]  score;
    } t_slot;

    // Adds or subtracts and clamps to the signed 32-bit range.
    function automatic logic signed [SCORE_W-1:0] sat_addsub(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b,
        input logic                      sub
    );
        logic signed [SCORE_W:0] s;
        logic signed [SCORE_W:0] ax;
        logic signed [SCORE_W:0] bx;
        ax = {a[SCORE_W-1], a};
        bx = {b[SCORE_W-1], b};
        s  = sub ? (ax - bx) : (ax + bx);
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            sat_addsub = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                    : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            sat_addsub = s[SCORE_W-1:0];
        end
    endfunction

endpackage

@@ src/hmi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the heap slots and the id-to-slot table.
module hmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

@@ src/hmi_queue.sv @@
// Small register queue with push/full and pop/empty sides.
// Stands alone; used for the command queue and the result queue.
module hmi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

@@ src/hmi_front.sv @@
// Front end: accepts commands, decodes them and checks the id range.
// Depends on hmi_pkg and hmi_queue, which buffers decoded requests.
module hmi_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          i_command,
    input  logic [hmi_pkg::ID_W-1:0]            i_contestant_id,
    input  logic signed [hmi_pkg::SCORE_W-1:0]  i_points,
    output hmi_pkg::t_req                       o_req,
    output logic                                o_req_valid,
    input  logic                                i_req_pop
);
    import hmi_pkg::*;

    t_req                  dec;
    logic [$bits(t_req)-1:0] q_out;
    logic                  q_empty;

    always_comb begin
        dec.id     = i_contestant_id;
        dec.points = i_points;
        dec.id_ok  = (i_contestant_id >= ID_W'(1)) && (i_contestant_id <= ID_W'(NUM_IDS));
        dec.idx    = IDX_W'(i_contestant_id - ID_W'(1));
        case (i_command)
            CMD_FIND:   dec.op = OP_FIND;
            CMD_INSERT: dec.op = OP_INSERT;
            CMD_REMOVE: dec.op = OP_REMOVE;
            CMD_ADD:    dec.op = OP_ADD;
            CMD_SUB:    dec.op = OP_SUB;
            CMD_CROWN:  dec.op = OP_CROWN;
            default:    dec.op = OP_NOP;
        endcase
    end

    hmi_queue #(
        .WIDTH ($bits(t_req)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec),
        .o_full  (full),
        .i_pop   (i_req_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign o_req       = t_req'(q_out);
    assign o_req_valid = !q_empty;
endmodule

@@ src/hmi_back.sv @@
// Back end: sequencer that executes one request on the heap memories.
// Depends on hmi_pkg and hmi_ram for the slot store and the id table.
module hmi_back #(
    parameter int CAPACITY = hmi_pkg::DEF_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hmi_pkg::t_req   i_req,
    input  logic            i_req_valid,
    output logic            o_req_pop,
    input  logic            i_res_room,
    output logic            o_res_push,
    output hmi_pkg::t_res   o_res
);
    import hmi_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic               r_pv, n_pv;
    logic [NUM_IDS-1:0] r_pvld;
    logic [SW-1:0]      r_hole, n_hole;
    logic [SW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_cidx, n_cidx;
    logic [ID_W-1:0]    r_mid, n_mid;
    logic signed [SCORE_W-1:0] r_ms, n_ms;
    t_slot              r_left, n_left;
    t_slot              r_child, n_child;
    t_res               r_res, n_res;

    logic               sl_we;
    logic [SW-1:0]      sl_wa, sl_ra;
    t_slot              sl_wd;
    logic [$bits(t_slot)-1:0] sl_q;
    t_slot              rd;
    logic               pm_we;
    logic [IDX_W-1:0]   pm_wa, pm_ra;
    logic [SW-1:0]      pm_wd, pm_q;
    logic               clr_we;
    logic [IDX_W-1:0]   clr_idx;

    logic [SW-1:0]      pos;
    logic [SW:0]        h2, h2p1, cnt_x;
    logic               down_ok, right_ok, start;

    assign rd       = t_slot'(sl_q);
    assign pos      = r_pv ? pm_q : '0;
    assign h2       = {r_hole, 1'b0};
    assign h2p1     = {r_hole, 1'b1};
    assign cnt_x    = {1'b0, r_count};
    assign down_ok  = (h2 <= cnt_x);
    assign right_ok = (h2p1 <= cnt_x);
    assign start    = i_req_valid && i_res_room;

    hmi_ram #(.WIDTH($bits(t_slot)), .DEPTH(CAPACITY + 1)) u_slots (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_wa),
        .i_wdata (sl_wd),
        .i_raddr (sl_ra),
        .o_rdata (sl_q)
    );

    hmi_ram #(.WIDTH(SW), .DEPTH(NUM_IDS)) u_posmap (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_wa),
        .i_wdata (pm_wd),
        .i_raddr (pm_ra),
        .o_rdata (pm_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                case (r_req.op)
                    OP_FIND, OP_ADD, OP_SUB: begin
                        n_state = (!r_req.id_ok || pos == '0) ? S_EMIT : S_RDSLOT;
                    end
                    OP_INSERT: begin
                        if (!r_req.id_ok) n_state = S_EMIT;
                        else if (pos != '0) n_state = S_RDSLOT;
                        else if (r_count >= SW'(CAPACITY)) n_state = S_EMIT;
                        else n_state = S_UP;
                    end
                    OP_REMOVE: n_state = (r_count == '0) ? S_EMIT : S_RDROOT;
                    OP_CROWN:  n_state = (r_count == '0) ? S_EMIT : S_CROWNNX;
                    default:   n_state = S_EMIT;
                endcase
            end
            S_RDSLOT: begin
                n_state = (r_req.op == OP_FIND || r_req.op == OP_INSERT) ? S_EMIT : S_UP;
            end
            S_UP:    n_state = (r_hole > SW'(1)) ? S_UPCMP : S_DOWN;
            S_UPCMP: n_state = (r_ms < rd.score) ? S_UP : S_DOWN;
            S_DOWN:  n_state = down_ok ? S_DL : S_PLACE;
            S_DL:    n_state = right_ok ? S_DR : S_DCMP;
            S_DR:    n_state = S_DCMP;
            S_DCMP:  n_state = (r_child.score < r_ms) ? S_DOWN : S_PLACE;
            S_PLACE: n_state = (r_req.op == OP_CROWN) ? S_CROWNNX : S_EMIT;
            S_CROWNNX: n_state = (r_count > SW'(1)) ? S_RDROOT : S_CROWNRD;
            S_RDROOT:  n_state = (r_count > SW'(1)) ? S_RDLAST : S_EMIT;
            S_RDLAST:  n_state = S_DOWN;
            S_CROWNRD: n_state = S_EMIT;
            S_EMIT:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req      = r_req;
        n_pv       = r_pv;
        n_hole     = r_hole;
        n_count    = r_count;
        n_cidx     = r_cidx;
        n_mid      = r_mid;
        n_ms       = r_ms;
        n_left     = r_left;
        n_child    = r_child;
        n_res      = r_res;
        sl_we      = 1'b0;
        sl_wa      = r_hole;
        sl_wd      = rd;
        sl_ra      = '0;
        pm_we      = 1'b0;
        pm_wa      = IDX_W'(rd.id - ID_W'(1));
        pm_wd      = r_hole;
        pm_ra      = i_req.idx;
        clr_we     = 1'b0;
        clr_idx    = IDX_W'(rd.id - ID_W'(1));
        o_req_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_req_pop = 1'b1;
                    n_req     = i_req;
                    n_pv      = r_pvld[i_req.idx];
                end
            end
            S_LOOKUP: begin
                n_res = '{STAT_OK, r_req.id, '0, '0, '0};
                case (r_req.op)
                    OP_FIND, OP_ADD, OP_SUB: begin
                        if (!r_req.id_ok || pos == '0) begin
                            n_res.status = STAT_NOTP;
                        end else begin
                            sl_ra  = pos;
                            n_hole = pos;
                        end
                    end
                    OP_INSERT: begin
                        if (!r_req.id_ok) begin
                            n_res.status = STAT_NOTP;
                        end else if (pos != '0) begin
                            sl_ra  = pos;
                            n_hole = pos;
                        end else if (r_count >= SW'(CAPACITY)) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            n_count = r_count + SW'(1);
                            n_hole  = r_count + SW'(1);
                            n_mid   = r_req.id;
                            n_ms    = r_req.points;
                        end
                    end
                    OP_REMOVE, OP_CROWN: begin
                        n_res.id = '0;
                        if (r_count == '0) begin
                            n_res.status = STAT_EMPTY;
                        end else begin
                            sl_ra = SW'(1);
                        end
                    end
                    default: n_res.id = '0;
                endcase
            end
            S_RDSLOT: begin
                if (r_req.op == OP_FIND || r_req.op == OP_INSERT) begin
                    n_res.status = (r_req.op == OP_INSERT) ? STAT_DUP : STAT_OK;
                    n_res.score  = rd.score;
                    n_res.loc    = ID_W'(r_hole);
                end else begin
                    n_mid = r_req.id;
                    n_ms  = sat_addsub(rd.score, r_req.points, r_req.op == OP_SUB);
                end
            end
            S_UP: begin
                sl_ra = r_hole >> 1;
            end
            S_UPCMP: begin
                if (r_ms < rd.score) begin
                    sl_we  = 1'b1;
                    pm_we  = 1'b1;
                    n_hole = r_hole >> 1;
                end
            end
            S_DOWN: begin
                sl_ra = h2[SW-1:0];
            end
            S_DL: begin
                n_left = rd;
                if (right_ok) begin
                    sl_ra = h2p1[SW-1:0];
                end else begin
                    n_child = rd;
                    n_cidx  = h2[SW-1:0];
                end
            end
            S_DR: begin
                if (rd.score < r_left.score) begin
                    n_child = rd;
                    n_cidx  = h2p1[SW-1:0];
                end else begin
                    n_child = r_left;
                    n_cidx  = h2[SW-1:0];
                end
            end
            S_DCMP: begin
                if (r_child.score < r_ms) begin
                    sl_we  = 1'b1;
                    sl_wd  = r_child;
                    pm_we  = 1'b1;
                    pm_wa  = IDX_W'(r_child.id - ID_W'(1));
                    n_hole = r_cidx;
                end
            end
            S_PLACE: begin
                sl_we = 1'b1;
                sl_wd = '{r_mid, r_ms};
                pm_we = 1'b1;
                pm_wa = IDX_W'(r_mid - ID_W'(1));
                if (r_req.op != OP_REMOVE && r_req.op != OP_CROWN) begin
                    n_res.score = r_ms;
                    n_res.loc   = ID_W'(r_hole);
                end
            end
            S_CROWNNX: begin
                sl_ra = SW'(1);
            end
            S_RDROOT: begin
                clr_we = 1'b1;
                if (r_req.op == OP_REMOVE) begin
                    n_res.id    = rd.id;
                    n_res.score = rd.score;
                    n_res.loc   = '0;
                end
                if (r_count > SW'(1)) begin
                    sl_ra = r_count;
                end else begin
                    n_count = r_count - SW'(1);
                end
            end
            S_RDLAST: begin
                n_mid   = rd.id;
                n_ms    = rd.score;
                n_count = r_count - SW'(1);
                n_hole  = SW'(1);
            end
            S_CROWNRD: begin
                n_res.id    = rd.id;
                n_res.score = rd.score;
                n_res.loc   = ID_W'(1);
            end
            S_EMIT: begin
                o_res_push = 1'b1;
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pvld  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (pm_we) begin
                r_pvld[pm_wa] <= 1'b1;
            end
            if (clr_we) begin
                r_pvld[clr_idx] <= 1'b0;
            end
        end
        r_req   <= n_req;
        r_pv    <= n_pv;
        r_hole  <= n_hole;
        r_cidx  <= n_cidx;
        r_mid   <= n_mid;
        r_ms    <= n_ms;
        r_left  <= n_left;
        r_child <= n_child;
        r_res   <= n_res;
    end

    always_comb begin
        o_res       = r_res;
        o_res.count = ID_W'(r_count);
    end
endmodule

@@ src/indexed_min_heap_core.sv @@
// Top level of the indexed min-heap: front decoder, heap sequencer, result queue.
// Depends on hmi_pkg, hmi_front, hmi_back and hmi_queue.
//
//   channel   handshake     payload
//   command   push / full   i_command, i_contestant_id, i_points
//   result    empty / pop   o_status, o_result_id, o_result_score, o_location,
//                           o_entry_count
//
// Commands are executed one at a time by the sequencer; each memory access is a
// separate state because the slot RAM has a single registered read port.
// Reset clears the count and the id valid bits at once, with no clearing pass.
// Two-entry queues on both sides let commands arrive while a result waits to be taken.
module indexed_min_heap_core #(
    parameter int CAPACITY = hmi_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          i_command,
    input  logic [hmi_pkg::ID_W-1:0]            i_contestant_id,
    input  logic signed [hmi_pkg::SCORE_W-1:0]  i_points,
    output logic                                empty,
    input  logic                                pop,
    output logic [2:0]                          o_status,
    output logic [hmi_pkg::ID_W-1:0]            o_result_id,
    output logic signed [hmi_pkg::SCORE_W-1:0]  o_result_score,
    output logic [hmi_pkg::ID_W-1:0]            o_location,
    output logic [hmi_pkg::ID_W-1:0]            o_entry_count
);
    import hmi_pkg::*;

    t_req                    req;
    logic                    req_valid;
    logic                    req_pop;
    t_res                    res_in;
    logic                    res_push;
    logic                    res_full;
    logic [$bits(t_res)-1:0] res_q;
    t_res                    res_out;

    hmi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_command       (i_command),
        .i_contestant_id (i_contestant_id),
        .i_points        (i_points),
        .o_req           (req),
        .o_req_valid     (req_valid),
        .i_req_pop       (req_pop)
    );

    hmi_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_pop   (req_pop),
        .i_res_room  (!res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    hmi_queue #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out        = t_res'(res_q);
    assign o_status       = res_out.status;
    assign o_result_id    = res_out.id;
    assign o_result_score = res_out.score;
    assign o_location     = res_out.loc;
    assign o_entry_count  = res_out.count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("Result pushed into a full result queue.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_entry_count <= ID_W'(NUM_IDS)))
        else $error("Entry count exceeds the number of ids.");

    a_fail_location: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != STAT_OK && o_status != STAT_DUP) |-> (o_location == '0))
        else $error("Failed transaction reports a nonzero location.");
endmodule
